>>> hw/rtl/ctb_pkg.sv
// shared types and constants for the combining tree barrier
// no dependencies; imported by ctb_ctrl, ctb_datapath and the top level
package ctb_pkg;

    localparam int TC_W  = 5;   // thread count register width
    localparam int TID_W = 4;   // thread id field width
    localparam int CNT_W = 2;   // node count width

    localparam logic [TC_W-1:0]  TC_RESET    = 5'd16;
    localparam logic [TC_W-1:0]  MIN_THREADS = 5'd2;
    localparam logic [CNT_W-1:0] FANIN_TWO   = 2'd2;
    localparam logic [CNT_W-1:0] FANIN_ONE   = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_UPDATE = 5'b00100,
        ST_READ   = 5'b01000,
        ST_POST   = 5'b10000
    } ctb_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the incoming thread id
        logic check;    // range and repeat check, read the leaf count
        logic update;   // decrement the node in hand
        logic read;     // read the count of the node in hand
        logic load;     // move the result into the output register
    } ctb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;      // arrival refused
        logic climb;    // count hit zero below the root
        logic out_free; // output register can take a word
    } ctb_sts_t;

endpackage

>>> hw/rtl/ctb_ctrl.sv
// sequencing state machine for the combining tree barrier
// depends on ctb_pkg; drives the ctb_datapath command struct
module ctb_ctrl
    import ctb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ctb_sts_t sts,
    output ctb_cmd_t cmd
);

    ctb_state_t state_reg;
    ctb_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = aresetn;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.err ? ST_POST : ST_UPDATE;
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = sts.climb ? ST_READ : ST_POST;
            end
            ST_READ: begin
                cmd.read   = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_POST: begin
                cmd.load = sts.out_free;
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/ctb_datapath.sv
// tree state, node count memory and output register of the barrier
// depends on ctb_pkg; sequenced by ctb_ctrl
module ctb_datapath
    import ctb_pkg::*;
#(
    parameter int MAX_THREADS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [TC_W-1:0]  cfg_wr_data,
    input  logic [TID_W-1:0] s_thread_id,
    input  ctb_cmd_t         cmd,
    output ctb_sts_t         sts,
    input  logic             m_ready,
    output logic             m_valid,
    output logic             m_release_res,
    output logic             m_episode_sense,
    output logic             m_arrival_error
);

    localparam int AW    = $clog2(MAX_THREADS);
    localparam int NODES = (1 << AW) - 1;
    localparam int NW    = $clog2(MAX_THREADS + 1);
    localparam int CMPW  = (NW > TC_W) ? NW : TC_W;

    // thread count saturated into 2..MAX_THREADS
    function automatic logic [NW-1:0] eff_threads(input logic [TC_W-1:0] tc);
        logic [CMPW-1:0] v;
        v = CMPW'(tc);
        if (v < CMPW'(MIN_THREADS)) begin
            v = CMPW'(MIN_THREADS);
        end else if (v > CMPW'(MAX_THREADS)) begin
            v = CMPW'(MAX_THREADS);
        end
        return NW'(v);
    endfunction

    // leaves-1 of the smallest power-of-two tree covering n threads
    function automatic logic [AW-1:0] leaf_mask(input logic [NW-1:0] n);
        logic [AW-1:0] m;
        m = '0;
        for (int k = 1; k <= AW; k++) begin
            if (n > (NW'(1) << (k - 1))) begin
                m = AW'((32'd1 << (k - 1)) - 32'd1);
            end
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] fan_in(input logic [AW-1:0] idx,
                                                input logic [NW-1:0] n);
        return (NW'(idx) < (n - NW'(1))) ? FANIN_TWO : FANIN_ONE;
    endfunction

    logic [TID_W-1:0]     tid_reg;
    logic [NW-1:0]        n_reg;
    logic [AW-1:0]        lmask_reg;
    logic [AW-1:0]        node_reg;
    logic [MAX_THREADS-1:0] arrived_reg;
    logic [NODES-1:0]     node_valid_reg;
    logic [NODES-1:0]     lock_sense_reg;
    logic [CNT_W-1:0]     node_count_mem [NODES];
    logic [CNT_W-1:0]     rd_data_reg;
    logic                 res_release_reg;
    logic                 res_sense_reg;
    logic                 res_error_reg;
    logic                 m_valid_reg;
    logic                 m_release_reg;
    logic                 m_sense_reg;
    logic                 m_error_reg;

    logic [NW-1:0]        cfg_n;
    logic [AW-1:0]        tid_a;
    logic                 out_of_range;
    logic                 arr_hit;
    logic [AW-1:0]        leaf;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic [CNT_W-1:0]     cur_cnt;
    logic [CNT_W-1:0]     new_cnt;
    logic                 at_root;
    logic [AW-1:0]        parent;
    logic                 release_now;
    logic                 mem_wr;

    assign cfg_n        = eff_threads(cfg_wr_data);
    assign tid_a        = AW'(tid_reg);
    assign out_of_range = CMPW'(tid_reg) >= CMPW'(n_reg);
    assign arr_hit      = out_of_range ? 1'b1 : arrived_reg[tid_a];
    assign leaf         = lmask_reg + (tid_a & lmask_reg);
    assign rd_addr      = cmd.check ? leaf : node_reg;
    assign rd_en        = cmd.check | cmd.read;

    // untouched nodes read as their fan-in
    assign cur_cnt  = node_valid_reg[node_reg] ? rd_data_reg : fan_in(node_reg, n_reg);
    assign new_cnt  = (cur_cnt != '0) ? (cur_cnt - CNT_W'(1)) : '0;
    assign at_root  = (node_reg == '0);
    assign parent   = (node_reg - AW'(1)) >> 1;

    assign release_now = cmd.update & (new_cnt == '0) & at_root;
    assign mem_wr      = cmd.update & ~release_now;

    assign sts.err      = arr_hit;
    assign sts.climb    = (new_cnt == '0) & ~at_root;
    assign sts.out_free = ~m_valid_reg | m_ready;

    // node count memory
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= node_count_mem[rd_addr];
        end
        if (mem_wr) begin
            node_count_mem[node_reg] <= new_cnt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg          <= eff_threads(TC_RESET);
            lmask_reg      <= leaf_mask(eff_threads(TC_RESET));
            arrived_reg    <= '0;
            node_valid_reg <= '0;
            lock_sense_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                n_reg          <= cfg_n;
                lmask_reg      <= leaf_mask(cfg_n);
                arrived_reg    <= '0;
                node_valid_reg <= '0;
                lock_sense_reg <= '0;
            end else if (release_now) begin
                arrived_reg    <= '0;
                node_valid_reg <= '0;
                lock_sense_reg <= {NODES{~lock_sense_reg[0]}};
            end else begin
                if (cmd.check && !arr_hit) begin
                    arrived_reg[tid_a] <= 1'b1;
                end
                if (mem_wr) begin
                    node_valid_reg[node_reg] <= 1'b1;
                end
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            tid_reg <= s_thread_id;
        end
        if (cmd.check) begin
            if (arr_hit) begin
                res_release_reg <= 1'b0;
                res_sense_reg   <= 1'b0;
                res_error_reg   <= 1'b1;
            end else begin
                node_reg <= leaf;
            end
        end
        if (cmd.update) begin
            if (sts.climb) begin
                node_reg <= parent;
            end else begin
                res_release_reg <= release_now;
                res_sense_reg   <= release_now & ~lock_sense_reg[0];
                res_error_reg   <= 1'b0;
            end
        end
        if (cmd.load) begin
            m_release_reg <= res_release_reg;
            m_sense_reg   <= res_sense_reg;
            m_error_reg   <= res_error_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_release_res   = m_release_reg;
    assign m_episode_sense = m_sense_reg;
    assign m_arrival_error = m_error_reg;

endmodule

>>> hw/rtl/combining_tree_barrier.sv
// combining tree barrier, top level: ctb_ctrl sequences ctb_datapath
// an accepted arrival is checked, updated at its leaf and up the tree, then posted;
//   a refused arrival goes straight to post; each level climbed (0 .. log2(MAX_THREADS)-1)
//   is a memory read then update; one arrival at a time: the next is taken once posted
// a finished word waits in the output register while the next arrival is taken
// reset (aresetn low, synchronous): 16 threads, all nodes at fan-in, sense 0, no arrivals
module combining_tree_barrier
    import ctb_pkg::*;
#(
    parameter int MAX_THREADS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    // thread count register, write only
    input  logic             cfg_wr_en,
    input  logic [TC_W-1:0]  cfg_wr_data,
    // arrival words
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [TID_W-1:0] s_thread_id,
    // result words
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_release_res,
    output logic             m_episode_sense,
    output logic             m_arrival_error
);

    // command and status between the sequencer and the tree datapath
    ctb_cmd_t cmd;
    ctb_sts_t sts;

    // sequencer: idle, check, then update / read pairs up the tree, then post
    ctb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath: arrived flags, node count memory with valid bits, lock sense,
    // and the output register that decouples the result side
    ctb_datapath #(
        .MAX_THREADS (MAX_THREADS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_thread_id     (s_thread_id),
        .cmd             (cmd),
        .sts             (sts),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_release_res   (m_release_res),
        .m_episode_sense (m_episode_sense),
        .m_arrival_error (m_arrival_error)
    );

`ifndef SYNTH
    // an update always works on count data read the cycle before
    a_update_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |-> $past(cmd.check || cmd.read))
        else $error("node update without a preceding count read");

    // an accepted arrival goes straight to its check
    a_accept_then_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.check)
        else $error("accepted arrival not checked");

    // a posted result shows up on the result side
    a_load_then_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> m_valid)
        else $error("posted result not presented");
`endif

endmodule
